FILE: rtl/tpr_pkg.sv
// Shared constants, codes and types of the telemetry poll responder
`timescale 1ns / 1ps

package tpr_pkg;

  // received frame store depth (stored bytes per frame, 2 to 15)
  localparam int RX_FRAME_BYTES = 8;
  localparam int RX_CNT_W       = $clog2(RX_FRAME_BYTES + 1);

  // answer packet length in unstuffed bytes
  localparam int PKT_LEN   = 8;
  localparam int PKT_CNT_W = $clog2(PKT_LEN);

  // depth of the answer queue between front and back
  localparam int ANS_QUEUE_DEPTH = 2;

  // line framing bytes
  localparam logic [7:0] FRAME_START = 8'h7E;
  localparam logic [7:0] FRAME_ESC   = 8'h7D;
  localparam logic [7:0] ESC_START   = 8'h5E;
  localparam logic [7:0] ESC_ESC     = 8'h5D;
  localparam logic [7:0] ESC_MASK    = 8'h5F;

  // input action codes
  localparam logic [1:0] ACT_RX   = 2'd0;
  localparam logic [1:0] ACT_LOAD = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE   = 2'd2;

  // one configuration write transaction
  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // one answer ready to send, bytes before stuffing
  typedef struct packed {
    logic                    data;
    logic [PKT_LEN-1:0][7:0] bytes;
  } answer_t;

endpackage

FILE: rtl/tpr_front.sv
// Front end: configuration registers, receive de-stuffing, poll detection, answer build
`timescale 1ns / 1ps

module tpr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  tpr_pkg::cfg_wr_t cfg_wr,
  input  logic             accept,
  input  logic [1:0]       action,
  input  logic [7:0]       rx_byte,
  input  logic [15:0]      sensor_id,
  input  logic [31:0]      sensor_value,
  output logic             push,
  output tpr_pkg::answer_t push_data
);

  localparam int SUM_W = 11;

  logic [7:0]  poll_id_r;
  logic [15:0] min_interval_r;
  logic [7:0]  frame_type_r;

  logic [tpr_pkg::RX_CNT_W-1:0] rx_count_r;
  logic        escape_r;
  logic        word_pending_r;
  logic [15:0] held_id_r;
  logic [31:0] held_value_r;
  logic [15:0] ms_r;

  logic             is_rx;
  logic             plain_byte;
  logic [7:0]       rx_unesc;
  logic             send_data;
  logic [SUM_W-1:0] sum;
  logic [15:0]      neg_sum;
  logic [7:0]       checksum;

  // receive byte decode
  always_comb begin
    is_rx      = accept && (action == tpr_pkg::ACT_RX);
    plain_byte = (rx_byte != tpr_pkg::FRAME_START) && (rx_byte != tpr_pkg::FRAME_ESC);
    rx_unesc   = rx_byte;
    if (escape_r && (rx_byte == tpr_pkg::ESC_START)) begin
      rx_unesc = tpr_pkg::FRAME_START;
    end else if (escape_r && (rx_byte == tpr_pkg::ESC_ESC)) begin
      rx_unesc = tpr_pkg::FRAME_ESC;
    end
    push = is_rx && plain_byte && (rx_count_r == '0) && (rx_unesc == poll_id_r);
  end

  // answer contents from the held word, or all zero bytes when no data answer is due
  always_comb begin
    send_data = word_pending_r && (ms_r >= min_interval_r);
    sum = {3'b0, frame_type_r} + {3'b0, held_id_r[7:0]} + {3'b0, held_id_r[15:8]}
        + {3'b0, held_value_r[7:0]} + {3'b0, held_value_r[15:8]}
        + {3'b0, held_value_r[23:16]} + {3'b0, held_value_r[31:24]};
    neg_sum  = 16'(17'h10000 - {6'b0, sum});
    checksum = 8'(neg_sum[7:0] + neg_sum[15:8]);
    push_data.data  = send_data;
    push_data.bytes = '0;
    if (send_data) begin
      push_data.bytes[0] = frame_type_r;
      push_data.bytes[1] = held_id_r[7:0];
      push_data.bytes[2] = held_id_r[15:8];
      push_data.bytes[3] = held_value_r[7:0];
      push_data.bytes[4] = held_value_r[15:8];
      push_data.bytes[5] = held_value_r[23:16];
      push_data.bytes[6] = held_value_r[31:24];
      push_data.bytes[tpr_pkg::PKT_LEN-1] = checksum;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_id_r      <= 8'd0;
      min_interval_r <= 16'd10;
      frame_type_r   <= 8'd16;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        tpr_pkg::REG_POLL_ID:      poll_id_r      <= cfg_wr.data[7:0];
        tpr_pkg::REG_MIN_INTERVAL: min_interval_r <= cfg_wr.data;
        tpr_pkg::REG_FRAME_TYPE:   frame_type_r   <= cfg_wr.data[7:0];
        default: ;
      endcase
    end
  end

  // frame, word and interval state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r     <= '0;
      escape_r       <= 1'b0;
      word_pending_r <= 1'b0;
      held_id_r      <= '0;
      held_value_r   <= '0;
      ms_r           <= '0;
    end else if (accept) begin
      unique case (action)
        tpr_pkg::ACT_LOAD: begin
          held_id_r      <= sensor_id;
          held_value_r   <= sensor_value;
          word_pending_r <= 1'b1;
        end
        tpr_pkg::ACT_TICK: begin
          if (ms_r < min_interval_r) begin
            ms_r <= ms_r + 16'd1;
          end
        end
        tpr_pkg::ACT_RX: begin
          if (rx_byte == tpr_pkg::FRAME_START) begin
            rx_count_r <= '0;
            escape_r   <= 1'b0;
          end else if (rx_byte == tpr_pkg::FRAME_ESC) begin
            escape_r <= 1'b1;
          end else begin
            escape_r <= 1'b0;
            if (push) begin
              if (send_data) begin
                ms_r           <= '0;
                word_pending_r <= 1'b0;
              end
            end else if (rx_count_r < tpr_pkg::RX_CNT_W'(tpr_pkg::RX_FRAME_BYTES)) begin
              rx_count_r <= rx_count_r + tpr_pkg::RX_CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/tpr_queue.sv
// Short answer queue between front end and transmit back end
`timescale 1ns / 1ps

module tpr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tpr_pkg::answer_t push_data,
  input  logic             pop,
  output tpr_pkg::answer_t head,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = tpr_pkg::ANS_QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  tpr_pkg::answer_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/tpr_back.sv
// Back end: byte stuffing serialiser with registered output
`timescale 1ns / 1ps

module tpr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tpr_pkg::answer_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  localparam int CNT_W = tpr_pkg::PKT_CNT_W;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(tpr_pkg::PKT_LEN - 1);

  logic                             active_r;
  logic                             esc_r;
  logic                             data_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic [tpr_pkg::PKT_LEN-1:0][7:0] pkt_r;
  logic                             out_tvalid_r;
  logic [7:0]                       out_tdata_r;
  logic                             out_tlast_r;
  logic                             out_tuser_r;

  logic advance;
  logic need_esc;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  // output slot free or being taken; load a new answer when idle
  assign advance  = !out_tvalid_r || out_tready;
  assign pop      = !active_r && !empty;
  assign need_esc = ((pkt_r[0] == tpr_pkg::FRAME_START) || (pkt_r[0] == tpr_pkg::FRAME_ESC))
                    && !esc_r;

  // serialiser control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      esc_r        <= 1'b0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (pop) begin
      active_r <= 1'b1;
      esc_r    <= 1'b0;
      cnt_r    <= '0;
      if (advance) begin
        out_tvalid_r <= 1'b0;
      end
    end else if (advance) begin
      out_tvalid_r <= active_r;
      if (active_r) begin
        if (need_esc) begin
          esc_r <= 1'b1;
        end else begin
          esc_r <= 1'b0;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == LAST_IDX) begin
            active_r <= 1'b0;
          end
        end
      end
    end
  end

  // packet bytes and output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      pkt_r  <= head.bytes;
      data_r <= head.data;
    end else if (advance && active_r) begin
      out_tuser_r <= data_r;
      if (need_esc) begin
        out_tdata_r <= tpr_pkg::FRAME_ESC;
        out_tlast_r <= 1'b0;
      end else begin
        out_tdata_r <= esc_r ? (pkt_r[0] & tpr_pkg::ESC_MASK) : pkt_r[0];
        out_tlast_r <= (cnt_r == LAST_IDX);
        for (int i = 0; i < tpr_pkg::PKT_LEN - 1; i++) begin
          pkt_r[i] <= pkt_r[i+1];
        end
        pkt_r[tpr_pkg::PKT_LEN-1] <= '0;
      end
    end
  end

endmodule

FILE: rtl/telemetry_poll_responder.sv
// Top level of the telemetry poll responder
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | tuser action, tdata rx byte, sensor id, value
//  out_    | out | out_tvalid / out_tready| tdata line byte, tlast end of answer, tuser data
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// One input transaction per cycle while the two-entry answer queue has room.
// A poll hit queues one answer; the back end loads it and sends it as 8 to 16
// line bytes from the stuffing serialiser, one line byte per cycle unless out_tready stalls.
// in_tready falls only while the queue is full; output stalls hold the byte.
// Synchronous active-low reset; no clearing pass, cfg_ready is always high.
`timescale 1ns / 1ps

module telemetry_poll_responder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // rx_byte[7:0], sensor_id[23:8], sensor_value[55:24]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // tx_byte[7:0]
  output logic        out_tlast,
  output logic        out_tuser,  // carries_data[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tpr_pkg::cfg_wr_t cfg_wr;
  tpr_pkg::answer_t push_data;
  tpr_pkg::answer_t head;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  logic             accept;

  // handshakes
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;
  assign in_tready    = !full;
  assign accept       = in_tvalid && in_tready;

  tpr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (cfg_wr),
    .accept       (accept),
    .action       (in_tuser),
    .rx_byte      (in_tdata[7:0]),
    .sensor_id    (in_tdata[23:8]),
    .sensor_value (in_tdata[55:24]),
    .push         (push),
    .push_data    (push_data)
  );

  tpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  tpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/tpr_checker.sv
// Port-level checks of the telemetry poll responder, bound to the top level
`timescale 1ns / 1ps

module tpr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // a stalled output transaction holds its byte
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output byte changed while stalled");

  // the frame start byte never appears in an answer
  a_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != tpr_pkg::FRAME_START)
    else $error("unstuffed frame start byte sent");

  // an escape is always followed by its byte, so the last byte is never a framing byte
  a_last_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata != tpr_pkg::FRAME_ESC &&
                                out_tdata != tpr_pkg::FRAME_START)
    else $error("answer ends on a framing byte");

  // zero packet carries only zero bytes
  a_zero_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 8'h00)
    else $error("non-zero byte in zero packet");

endmodule

bind telemetry_poll_responder tpr_checker u_tpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

FILE: sim/tb_top.sv
// Self-checking testbench for the telemetry poll responder
`timescale 1ns / 1ps

module tb_top;

  // action code the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int ITEMS_PER_PHASE = 75;
  localparam int N_PHASES        = 6;
  // two queued answers plus one draining, each up to 16 bytes and its load step
  localparam int DRAIN_CYCLES    = 60;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 40;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // how the answer to one input transaction is checked
  typedef enum logic [2:0] {
    CHK_MODEL,      // predicted
    CHK_QUIET,      // no answer at all
    CHK_ZERO_PKT,   // eight zero bytes, no sensor word
    CHK_ZERO_DATA,  // data answer whose bytes are all zero
    CHK_ONES_DATA   // data answer of seven 0xff bytes and a zero checksum
  } chk_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
    logic       carries;
  } line_byte_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  act;
    logic [7:0]  rx;
    logic [15:0] sid;
    logic [31:0] sval;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    chk_t        chk;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // rx_byte[7:0], sensor_id[23:8], sensor_value[55:24]
  logic [1:0]  in_tuser = '0;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // tx_byte[7:0]
  logic        out_tlast;
  logic        out_tuser;       // carries_data[0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  telemetry_poll_responder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // responder state as the line should see it
  logic [7:0]  poll_reg     = 8'd0;
  logic [15:0] interval_reg = 16'd10;
  logic [7:0]  ftype_reg    = 8'd16;
  int          frame_len    = 0;
  logic [7:0]  frame_head   = 8'd0;
  logic        esc_armed    = 1'b0;
  logic        word_held    = 1'b0;
  logic [15:0] word_id      = 16'd0;
  logic [31:0] word_value   = 32'd0;
  logic [15:0] ms_count     = 16'd0;

  line_byte_t  new_tx [$];      // bytes caused by the latest input transaction
  line_byte_t  pending_tx [$];  // line bytes still owed by the block
  chk_t        chk_order [$];   // check mode of each offered input transaction
  stim_row_t   dir_rows [$];

  int   mismatches = 0;
  int   items_counted = 0;
  int   items_taken = 0;
  int   cfg_writes = 0;
  int   bytes_seen = 0;
  int   data_answers = 0;
  int   zero_answers = 0;
  int   quiet_cycles = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  bit   hold_req = 1'b0;

  chk_t       chk;
  line_byte_t lb;
  line_byte_t want;
  int         k;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
  endtask

  // idle length: none outside pct percent of calls, else mostly short, now and then long
  function automatic int gap_len(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // byte biased towards the framing and escape codes
  function automatic logic [7:0] rand_line_byte();
    case ($urandom_range(0, 9))
      0: return tpr_pkg::FRAME_START;
      1: return tpr_pkg::FRAME_ESC;
      2: return ($urandom_range(0, 1) != 0) ? tpr_pkg::ESC_START : tpr_pkg::ESC_ESC;
      default: return 8'($urandom);
    endcase
  endfunction

  // advance the responder by one input transaction, answer bytes go to new_tx
  task automatic responder_step(input logic [1:0] act, input logic [7:0] rx,
                                input logic [15:0] sid, input logic [31:0] sval);
    logic [7:0]  c;
    logic [7:0]  pkt [tpr_pkg::PKT_LEN];
    logic [15:0] csum;
    logic        carries;
    line_byte_t  b;
    int          i;
    new_tx.delete();
    c = rx;
    if (act == tpr_pkg::ACT_LOAD) begin
      word_id = sid;
      word_value = sval;
      word_held = 1'b1;
    end else if (act == tpr_pkg::ACT_TICK) begin
      if (ms_count < interval_reg) ms_count++;
    end else if (act == tpr_pkg::ACT_RX && c == tpr_pkg::FRAME_START) begin
      frame_len = 0;
      frame_head = 8'd0;
      esc_armed = 1'b0;
    end else if (act == tpr_pkg::ACT_RX && c == tpr_pkg::FRAME_ESC) begin
      esc_armed = 1'b1;
    end else if (act == tpr_pkg::ACT_RX) begin
      // only the two framing codes are restored, other escaped bytes pass
      if (esc_armed) begin
        if (c == tpr_pkg::ESC_START) c = tpr_pkg::FRAME_START;
        else if (c == tpr_pkg::ESC_ESC) c = tpr_pkg::FRAME_ESC;
        esc_armed = 1'b0;
      end
      if (frame_len < tpr_pkg::RX_FRAME_BYTES) begin
        if (frame_len == 0) frame_head = c;
        frame_len++;
      end
      // poll hit on the first stored byte
      if (frame_len < tpr_pkg::RX_FRAME_BYTES && frame_len == 1 &&
          frame_head == poll_reg) begin
        carries = word_held && (ms_count >= interval_reg);
        for (i = 0; i < tpr_pkg::PKT_LEN; i++) pkt[i] = 8'h00;
        if (carries) begin
          pkt[0] = ftype_reg;
          pkt[1] = word_id[7:0];
          pkt[2] = word_id[15:8];
          for (i = 0; i < 4; i++) pkt[3 + i] = word_value[8 * i +: 8];
          csum = 16'h0000;
          for (i = 0; i < tpr_pkg::PKT_LEN - 1; i++) csum = csum - {8'h00, pkt[i]};
          pkt[tpr_pkg::PKT_LEN - 1] = csum[7:0] + csum[15:8];
          ms_count = 16'd0;
          word_held = 1'b0;
        end
        // byte stuffing on the way out
        for (i = 0; i < tpr_pkg::PKT_LEN; i++) begin
          if (pkt[i] == tpr_pkg::FRAME_START || pkt[i] == tpr_pkg::FRAME_ESC) begin
            b.tx = tpr_pkg::FRAME_ESC;
            b.last = 1'b0;
            b.carries = carries;
            new_tx.push_back(b);
            pkt[i] = pkt[i] & tpr_pkg::ESC_MASK;
          end
          b.tx = pkt[i];
          b.last = (i == tpr_pkg::PKT_LEN - 1);
          b.carries = carries;
          new_tx.push_back(b);
        end
        frame_len = 0;
        frame_head = 8'd0;
      end
    end
  endtask

  // input and configuration transactions feed the prediction
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      cfg_writes++;
      case (cfg_index)
        tpr_pkg::REG_POLL_ID:      poll_reg = cfg_data[7:0];
        tpr_pkg::REG_MIN_INTERVAL: interval_reg = cfg_data;
        tpr_pkg::REG_FRAME_TYPE:   ftype_reg = cfg_data[7:0];
        default: ;
      endcase
    end
    if (rst_n && in_tvalid && in_tready) begin
      items_taken++;
      chk = chk_order.pop_front();
      responder_step(in_tuser, in_tdata[7:0], in_tdata[23:8], in_tdata[55:24]);
      if (chk == CHK_MODEL) begin
        foreach (new_tx[j]) pending_tx.push_back(new_tx[j]);
      end else if (chk != CHK_QUIET) begin
        for (k = 0; k < tpr_pkg::PKT_LEN; k++) begin
          lb.tx = (chk == CHK_ONES_DATA && k < tpr_pkg::PKT_LEN - 1) ? 8'hFF : 8'h00;
          lb.last = (k == tpr_pkg::PKT_LEN - 1);
          lb.carries = (chk != CHK_ZERO_PKT);
          pending_tx.push_back(lb);
        end
      end
    end
  end

  // line byte checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      bytes_seen++;
      if (out_tlast && out_tuser) data_answers++;
      else if (out_tlast) zero_answers++;
      if (pending_tx.size() == 0) begin
        report_mismatch($sformatf("unexpected line byte %02h", out_tdata));
      end else begin
        want = pending_tx.pop_front();
        if (out_tdata !== want.tx)
          report_mismatch($sformatf("tx_byte %02h, want %02h", out_tdata, want.tx));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last_byte %b, want %b on byte %02h",
                                    out_tlast, want.last, want.tx));
        if (out_tuser !== want.carries)
          report_mismatch($sformatf("carries_data %b, want %b on byte %02h",
                                    out_tuser, want.carries, want.tx));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without a transaction", quiet_cycles);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold on request
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = gap_len(rx_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [7:0] rx,
                           input logic [15:0] sid, input logic [31:0] sval,
                           input chk_t mode);
    int gap;
    gap = gap_len(tx_idle_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {sval, sid, rx};
    chk_order.push_back(mode);
    do @(posedge clk); while (!in_tready);
    if (act != ACT_UNUSED) items_counted++;
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_item(tpr_pkg::ACT_RX, b, 16'($urandom), $urandom, CHK_MODEL);
  endtask

  task automatic send_tick();
    send_item(tpr_pkg::ACT_TICK, 8'($urandom), 16'($urandom), $urandom, CHK_MODEL);
  endtask

  task automatic send_load();
    send_item(tpr_pkg::ACT_LOAD, 8'($urandom), {rand_line_byte(), rand_line_byte()},
              {rand_line_byte(), rand_line_byte(), rand_line_byte(), rand_line_byte()},
              CHK_MODEL);
  endtask

  // poll byte, escaped on the line where it is a framing code
  task automatic send_poll(input logic [7:0] poll);
    if (poll == tpr_pkg::FRAME_START) begin
      send_rx(tpr_pkg::FRAME_ESC);
      send_rx(tpr_pkg::ESC_START);
    end else if (poll == tpr_pkg::FRAME_ESC) begin
      send_rx(tpr_pkg::FRAME_ESC);
      send_rx(tpr_pkg::ESC_ESC);
    end else begin
      send_rx(poll);
    end
  endtask

  // register write, only once all owed bytes are out and the block has settled
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_tx.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_item(input logic [1:0] act, input logic [7:0] rx,
                          input logic [15:0] sid, input logic [31:0] sval,
                          input chk_t mode);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.act = act;
    r.rx = rx;
    r.sid = sid;
    r.sval = sval;
    r.reg_idx = tpr_pkg::REG_POLL_ID;
    r.reg_val = 16'd0;
    r.chk = mode;
    dir_rows.push_back(r);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [15:0] val);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.act = tpr_pkg::ACT_RX;
    r.rx = 8'd0;
    r.sid = 16'd0;
    r.sval = 32'd0;
    r.reg_idx = idx;
    r.reg_val = val;
    r.chk = CHK_QUIET;
    dir_rows.push_back(r);
  endtask

  // one random sequence, mostly well-formed polls with random content
  task automatic random_burst(input logic [7:0] poll);
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      n = $urandom_range(0, 4);
      repeat (n) send_tick();
      if ($urandom_range(0, 9) < 7) send_load();
      if ($urandom_range(0, 3) != 0) send_rx(tpr_pkg::FRAME_START);
      send_poll(poll);
    end else if (pick < 70) begin
      send_rx(rand_line_byte());
    end else if (pick < 80) begin
      n = $urandom_range(1, 6);
      repeat (n) send_tick();
    end else if (pick < 88) begin
      // frame that may run past the store
      send_rx(tpr_pkg::FRAME_START);
      n = $urandom_range(1, tpr_pkg::RX_FRAME_BYTES + 4);
      repeat (n) send_rx(rand_line_byte());
    end else if (pick < 94) begin
      send_item(ACT_UNUSED, 8'($urandom), 16'($urandom), $urandom, CHK_MODEL);
    end else begin
      send_rx(tpr_pkg::FRAME_ESC);
      send_rx(rand_line_byte());
    end
  endtask

  initial begin : stimulus
    logic [7:0]  poll;
    logic [15:0] interval;
    logic [7:0]  ftype;
    int          target;
    int          phase;

    // directed rows
    add_item(tpr_pkg::ACT_RX, 8'h00, 16'h0000, 32'h0000_0000, CHK_ZERO_PKT);  // poll, no word
    add_item(ACT_UNUSED, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, CHK_QUIET);
    add_item(tpr_pkg::ACT_LOAD, 8'hFF, 16'h1234, 32'h7E7D_5E5D, CHK_QUIET);
    // interval not reached
    add_item(tpr_pkg::ACT_RX, 8'h00, 16'h0000, 32'h0000_0000, CHK_ZERO_PKT);
    add_cfg(tpr_pkg::REG_MIN_INTERVAL, 16'd1);
    add_item(tpr_pkg::ACT_TICK, 8'h00, 16'h0000, 32'h0000_0000, CHK_QUIET);
    add_item(tpr_pkg::ACT_TICK, 8'h00, 16'h0000, 32'h0000_0000, CHK_QUIET);  // saturates
    add_item(tpr_pkg::ACT_RX, tpr_pkg::FRAME_START, 16'h0000, 32'h0000_0000, CHK_QUIET);
    add_item(tpr_pkg::ACT_RX, 8'h00, 16'h0000, 32'h0000_0000, CHK_MODEL);  // stuffed data answer
    add_cfg(tpr_pkg::REG_POLL_ID, {8'hA5, tpr_pkg::FRAME_START});
    add_item(tpr_pkg::ACT_RX, tpr_pkg::FRAME_ESC, 16'h0000, 32'h0000_0000, CHK_QUIET);
    add_item(tpr_pkg::ACT_RX, tpr_pkg::ESC_START, 16'h0000, 32'h0000_0000, CHK_ZERO_PKT);
    add_item(tpr_pkg::ACT_RX, tpr_pkg::FRAME_ESC, 16'h0000, 32'h0000_0000, CHK_QUIET);
    add_item(tpr_pkg::ACT_RX, 8'h41, 16'h0000, 32'h0000_0000, CHK_QUIET);  // plain escaped byte
    add_item(tpr_pkg::ACT_RX, tpr_pkg::FRAME_START, 16'h0000, 32'h0000_0000, CHK_QUIET);
    add_cfg(tpr_pkg::REG_POLL_ID, 16'h00FF);
    add_cfg(tpr_pkg::REG_MIN_INTERVAL, 16'd0);
    add_cfg(tpr_pkg::REG_FRAME_TYPE, 16'h00FF);
    add_item(tpr_pkg::ACT_LOAD, 8'h00, 16'h0000, 32'h0000_0000, CHK_QUIET);
    add_item(tpr_pkg::ACT_LOAD, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, CHK_QUIET);  // reload replaces
    add_item(tpr_pkg::ACT_RX, 8'hFF, 16'h0000, 32'h0000_0000, CHK_ONES_DATA);
    add_cfg(tpr_pkg::REG_FRAME_TYPE, 16'hFF00);
    add_item(tpr_pkg::ACT_LOAD, 8'h00, 16'h0000, 32'h0000_0000, CHK_QUIET);
    add_item(tpr_pkg::ACT_RX, 8'hFF, 16'h0000, 32'h0000_0000, CHK_ZERO_DATA);
    add_cfg(tpr_pkg::REG_MIN_INTERVAL, 16'hFFFF);
    add_item(tpr_pkg::ACT_LOAD, 8'h00, 16'hA55A, 32'h1234_5678, CHK_QUIET);
    add_item(tpr_pkg::ACT_TICK, 8'h00, 16'h0000, 32'h0000_0000, CHK_QUIET);
    add_item(tpr_pkg::ACT_RX, 8'hFF, 16'h0000, 32'h0000_0000, CHK_ZERO_PKT);  // too early
    add_cfg(tpr_pkg::REG_MIN_INTERVAL, 16'd0);  // count above interval
    add_item(tpr_pkg::ACT_RX, 8'hFF, 16'h0000, 32'h0000_0000, CHK_MODEL);
    add_item(tpr_pkg::ACT_RX, tpr_pkg::FRAME_ESC, 16'h0000, 32'h0000_0000, CHK_QUIET);
    add_item(tpr_pkg::ACT_RX, tpr_pkg::ESC_ESC, 16'h0000, 32'h0000_0000, CHK_QUIET);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 25;
    rx_idle_pct = 25;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else send_item(dir_rows[i].act, dir_rows[i].rx, dir_rows[i].sid, dir_rows[i].sval,
                     dir_rows[i].chk);
    end

    // random phases, each under its own register setting and idle pattern
    for (phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: begin
          poll = 8'($urandom); interval = 16'd2; ftype = tpr_pkg::FRAME_START;
          tx_idle_pct = 0; rx_idle_pct = 0;
        end
        1: begin
          poll = tpr_pkg::FRAME_START; interval = 16'd0; ftype = 8'($urandom);
          tx_idle_pct = 20; rx_idle_pct = 30;
        end
        2: begin
          poll = 8'($urandom); interval = 16'hFFFF; ftype = 8'hFF;
          tx_idle_pct = 50; rx_idle_pct = 60;
        end
        3: begin
          poll = tpr_pkg::FRAME_ESC; interval = 16'd3; ftype = 8'($urandom);
          tx_idle_pct = 0; rx_idle_pct = 20;
        end
        4: begin
          poll = 8'h00; interval = 16'($urandom_range(0, 8)); ftype = 8'h00;
          tx_idle_pct = 30; rx_idle_pct = 0;
        end
        default: begin
          poll = 8'hFF; interval = 16'd1; ftype = tpr_pkg::FRAME_ESC;
          tx_idle_pct = 10; rx_idle_pct = 40;
        end
      endcase
      write_reg(tpr_pkg::REG_POLL_ID, {8'($urandom), poll});
      write_reg(tpr_pkg::REG_MIN_INTERVAL, interval);
      write_reg(tpr_pkg::REG_FRAME_TYPE, {8'($urandom), ftype});

      // long receiver hold while polls keep coming, so the answer queue fills
      if (phase == 1) begin
        hold_req = 1'b1;
        repeat (8) begin
          send_load();
          send_rx(tpr_pkg::FRAME_START);
          send_poll(poll);
        end
      end

      target = items_counted + ITEMS_PER_PHASE;
      while (items_counted < target) random_burst(poll);
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_tx.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input transactions over %0d register writes",
             items_taken, cfg_writes);
    $display("%0d line bytes checked: %0d data answers, %0d zero packets, %0d mismatches",
             bytes_seen, data_answers, zero_answers, mismatches);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
